[hdl/fagr_pkg.sv]
// Shared types and constants of the font atlas glyph renderer.
// No dependencies; fagr_front, fagr_fifo, fagr_back and the top level import it.
package fagr_pkg;

    localparam int GLYPH_COUNT = 95;
    localparam int GIDX_W      = 7;
    localparam int FULL_AW     = 23;

    localparam logic [7:0] FIRST_CODE   = 8'd32;
    localparam logic [7:0] LAST_CODE    = 8'd126;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic [1:0] CMD_SET_PEN = 2'd0;
    localparam logic [1:0] CMD_DRAW    = 2'd1;
    localparam logic [1:0] CMD_GLYPH   = 2'd2;
    localparam logic [1:0] CMD_TEXEL   = 2'd3;

    localparam logic [1:0] REG_FONT_READY  = 2'd0;
    localparam logic [1:0] REG_ATLAS_WIDTH = 2'd1;
    localparam logic [1:0] REG_LINE_PITCH  = 2'd2;

    localparam logic [10:0] ATLAS_WIDTH_RST = 11'd256;
    localparam logic [7:0]  LINE_PITCH_RST  = 8'd16;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SET_PEN,
        OP_GLYPH,
        OP_TEXEL,
        OP_NEWLINE,
        OP_DRAW,
        OP_DRAW_NONE
    } op_t;

    typedef struct packed {
        logic [9:0] ax;
        logic [9:0] ay;
        logic [4:0] w;
        logic [4:0] h;
        logic [7:0] offx;
        logic [7:0] offy;
        logic [7:0] adv;
    } glyph_t;

    typedef struct packed {
        op_t               op;
        logic [GIDX_W-1:0] gidx;
        logic [15:0]       pen_x;
        logic [15:0]       pen_y;
        glyph_t            glyph;
        logic [7:0]        alpha;
    } cmd_t;

    typedef struct packed {
        logic        font_ready;
        logic [10:0] atlas_width;
        logic [7:0]  line_pitch;
    } cfg_t;

endpackage

[hdl/fagr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fagr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/fagr_front.sv]
// Front end: takes commands, classifies them and clamps glyph metrics.
// Depends on fagr_pkg.
module fagr_front #(
    parameter int GLYPH_MAX_W = 16,
    parameter int GLYPH_MAX_H = 24
) (
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [1:0]            command,
    input  logic [7:0]            char_code,
    input  logic [15:0]           pen_x,
    input  logic [15:0]           pen_y,
    input  logic [9:0]            atlas_x,
    input  logic [9:0]            atlas_y,
    input  logic [4:0]            glyph_width,
    input  logic [4:0]            glyph_height,
    input  logic [7:0]            glyph_offset_x,
    input  logic [7:0]            glyph_offset_y,
    input  logic [7:0]            glyph_advance,
    input  logic [31:0]           texel_word,
    input  logic                  q_full,
    output logic                  q_push,
    output fagr_pkg::cmd_t        q_data
);
    import fagr_pkg::*;

    logic printable;

    assign cmd_ready = !q_full;
    assign q_push    = cmd_valid && !q_full;

    always_comb
    begin
        printable = char_code inside {[FIRST_CODE:LAST_CODE]};
        q_data.gidx  = GIDX_W'(char_code - FIRST_CODE);
        q_data.pen_x = pen_x;
        q_data.pen_y = pen_y;
        q_data.glyph.ax = atlas_x;
        q_data.glyph.ay = atlas_y;
        q_data.glyph.w  = (glyph_width > 5'(GLYPH_MAX_W)) ? 5'(GLYPH_MAX_W) : glyph_width;
        q_data.glyph.h  = (glyph_height > 5'(GLYPH_MAX_H)) ? 5'(GLYPH_MAX_H) : glyph_height;
        q_data.glyph.offx = glyph_offset_x;
        q_data.glyph.offy = glyph_offset_y;
        q_data.glyph.adv  = glyph_advance;
        q_data.alpha = texel_word[31:24];
        case (command)
            CMD_SET_PEN: q_data.op = OP_SET_PEN;
            CMD_DRAW:
            begin
                if (char_code == NEWLINE_CODE)
                    q_data.op = OP_NEWLINE;
                else if (printable)
                    q_data.op = OP_DRAW;
                else
                    q_data.op = OP_DRAW_NONE;
            end
            CMD_GLYPH:   q_data.op = printable ? OP_GLYPH : OP_NOP;
            CMD_TEXEL:   q_data.op = OP_TEXEL;
            default:     q_data.op = OP_NOP;
        endcase
    end
endmodule

[hdl/fagr_fifo.sv]
// Two-entry command queue between front end and back end.
// Depends on fagr_pkg.
module fagr_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fagr_pkg::cmd_t push_data,
    input  logic           pop,
    output fagr_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import fagr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[hdl/fagr_back.sv]
// Back end: runs queued commands, owns the glyph table, atlas and pen.
// Depends on fagr_pkg and fagr_ram.
module fagr_back #(
    parameter int ATLAS_TEXELS = 65536,
    parameter int LANES        = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fagr_pkg::cfg_t cfg,
    input  logic           q_empty,
    input  fagr_pkg::cmd_t q_head,
    output logic           q_pop,
    input  logic           res_ready,
    output logic           res_valid,
    output logic           kind,
    output logic [15:0]    screen_x,
    output logic [15:0]    screen_y,
    output logic [63:0]    alphas,
    output logic [7:0]     lane_mask,
    output logic           last
);
    import fagr_pkg::*;

    localparam int AW  = $clog2(ATLAS_TEXELS);
    localparam int LNW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [FULL_AW-1:0] ATLAS_LIMIT = FULL_AW'(ATLAS_TEXELS);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_TWR, S_GCAP, S_ROW, S_LANE, S_FLUSH, S_EMIT, S_DONE
    } state_t;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    glyph_t               g_reg;
    logic [15:0]          pen_x_reg;
    logic [15:0]          pen_y_reg;
    logic [15:0]          line_start_reg;
    logic [15:0]          bx_reg;
    logic [15:0]          by_reg;
    logic [4:0]           iy_reg;
    logic [4:0]           cx_reg;
    logic [LNW-1:0]       ln_reg;
    logic [FULL_AW-1:0]   prod_reg;
    logic [FULL_AW-1:0]   row_base_reg;
    logic                 cap_vld_reg;
    logic                 cap_ok_reg;
    logic [LNW-1:0]       cap_lane_reg;
    logic [7:0]           acc_reg [LANES];
    logic                 res_valid_reg;
    logic                 kind_reg;
    logic [15:0]          sx_reg;
    logic [15:0]          sy_reg;
    logic [63:0]          alphas_reg;
    logic [7:0]           mask_reg;
    logic                 last_reg;

    logic                 gl_we;
    glyph_t               gl_rdata;
    logic                 at_we;
    logic [7:0]           at_rdata;
    logic [FULL_AW-1:0]   tex_full;
    logic [FULL_AW-1:0]   rd_full;
    logic [4:0]           ix;
    logic [4:0]           cx_step;
    logic [10:0]          row;
    logic                 out_free;
    logic                 res_load;
    logic                 lane_last;
    logic [63:0]          pack_alphas;
    logic [7:0]           pack_mask;

    fagr_ram #(.WIDTH($bits(glyph_t)), .DEPTH(GLYPH_COUNT)) u_glyph_ram (
        .clk   (clk),
        .we    (gl_we),
        .waddr (cmd_reg.gidx),
        .wdata (cmd_reg.glyph),
        .raddr (cmd_reg.gidx),
        .rdata (gl_rdata)
    );

    fagr_ram #(.WIDTH(8), .DEPTH(ATLAS_TEXELS)) u_atlas_ram (
        .clk   (clk),
        .we    (at_we),
        .waddr (tex_full[AW-1:0]),
        .wdata (cmd_reg.alpha),
        .raddr (rd_full[AW-1:0]),
        .rdata (at_rdata)
    );

    always_comb
    begin
        q_pop     = (state_reg == S_IDLE) && !q_empty;
        gl_we     = (state_reg == S_EXEC) && (cmd_reg.op == OP_GLYPH);
        tex_full  = prod_reg + FULL_AW'(cmd_reg.glyph.ax);
        at_we     = (state_reg == S_TWR) && (tex_full < ATLAS_LIMIT);
        ix        = cx_reg + 5'(ln_reg);
        rd_full   = row_base_reg + FULL_AW'(g_reg.ax) + FULL_AW'(ix);
        cx_step   = cx_reg + 5'(LANES);
        row       = 11'(g_reg.ay) + 11'(iy_reg);
        out_free  = !res_valid_reg || res_ready;
        res_load  = ((state_reg == S_EMIT) || (state_reg == S_DONE)) && out_free;
        lane_last = (ln_reg == LNW'(LANES - 1)) || (ix + 5'd1 >= g_reg.w);
        pack_alphas = '0;
        pack_mask   = '0;
        for (int i = 0; i < LANES; i++)
        begin
            pack_alphas[8*i +: 8] = acc_reg[i];
            pack_mask[i]          = acc_reg[i] != 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            line_start_reg <= '0;
            cap_vld_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            // capture the atlas byte of the lane read last cycle
            cap_vld_reg <= 1'b0;
            if (cap_vld_reg)
                acc_reg[cap_lane_reg] <= cap_ok_reg ? at_rdata : 8'd0;

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cmd_reg   <= q_head;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    prod_reg <= FULL_AW'(cmd_reg.glyph.ay) * FULL_AW'(cfg.atlas_width);
                    case (cmd_reg.op)
                        OP_SET_PEN:
                        begin
                            pen_x_reg      <= cmd_reg.pen_x;
                            pen_y_reg      <= cmd_reg.pen_y;
                            line_start_reg <= cmd_reg.pen_x;
                            state_reg      <= S_DONE;
                        end
                        OP_TEXEL:     state_reg <= S_TWR;
                        OP_NEWLINE:
                        begin
                            if (cfg.font_ready)
                            begin
                                pen_y_reg <= pen_y_reg + 16'(cfg.line_pitch);
                                pen_x_reg <= line_start_reg;
                            end
                            state_reg <= S_DONE;
                        end
                        OP_DRAW:      state_reg <= cfg.font_ready ? S_GCAP : S_DONE;
                        OP_DRAW_NONE: state_reg <= S_DONE;
                        default:      state_reg <= S_IDLE;
                    endcase
                end
                S_TWR:        state_reg <= S_IDLE;
                S_GCAP:
                begin
                    g_reg  <= gl_rdata;
                    bx_reg <= pen_x_reg + {{8{gl_rdata.offx[7]}}, gl_rdata.offx};
                    by_reg <= pen_y_reg + {{8{gl_rdata.offy[7]}}, gl_rdata.offy};
                    iy_reg <= '0;
                    cx_reg <= '0;
                    if (gl_rdata.w == 5'd0 || gl_rdata.h == 5'd0)
                    begin
                        pen_x_reg <= pen_x_reg + 16'(gl_rdata.adv);
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    row_base_reg <= FULL_AW'(row) * FULL_AW'(cfg.atlas_width);
                    ln_reg       <= '0;
                    for (int i = 0; i < LANES; i++)
                        acc_reg[i] <= 8'd0;
                    state_reg <= S_LANE;
                end
                S_LANE:
                begin
                    cap_vld_reg  <= 1'b1;
                    cap_lane_reg <= ln_reg;
                    cap_ok_reg   <= rd_full < ATLAS_LIMIT;
                    if (lane_last)
                        state_reg <= S_FLUSH;
                    else
                        ln_reg <= ln_reg + 1'b1;
                end
                S_FLUSH:      state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= 1'b0;
                        sx_reg        <= bx_reg + 16'(cx_reg);
                        sy_reg        <= by_reg + 16'(iy_reg);
                        alphas_reg    <= pack_alphas;
                        mask_reg      <= pack_mask;
                        last_reg      <= 1'b0;
                        if (cx_step < g_reg.w)
                        begin
                            cx_reg <= cx_step;
                            ln_reg <= '0;
                            for (int i = 0; i < LANES; i++)
                                acc_reg[i] <= 8'd0;
                            state_reg <= S_LANE;
                        end
                        else if (iy_reg + 5'd1 < g_reg.h)
                        begin
                            iy_reg    <= iy_reg + 5'd1;
                            cx_reg    <= '0;
                            state_reg <= S_ROW;
                        end
                        else
                        begin
                            pen_x_reg <= pen_x_reg + 16'(g_reg.adv);
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= 1'b1;
                        sx_reg        <= pen_x_reg;
                        sy_reg        <= pen_y_reg;
                        alphas_reg    <= '0;
                        mask_reg      <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:      state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign alphas    = alphas_reg;
    assign lane_mask = mask_reg;
    assign last      = last_reg;
endmodule

[hdl/font_atlas_glyph_renderer_core.sv]
// Top level of the font atlas glyph renderer: APB registers, front end,
// command queue and back end. Depends on fagr_pkg, fagr_front, fagr_fifo, fagr_back.
//
//   channel   handshake              payload
//   command   cmd_valid / cmd_ready  command .. texel_word, one request per command
//   result    res_valid / res_ready  kind, screen_x/y, alphas, lane_mask, last
//   config    APB psel/penable       paddr[3:2] selects font_ready, atlas_width,
//                                    line pitch
//
// A set pen gives its done result directly. A draw first reads the glyph
// table, then per row computes the row address with a multiply, and per
// chunk reads each covered lane in turn, then flushes the last atlas read
// and loads the result. The single atlas read port allows one texel per cycle.
// Reset: asynchronous, clears pen, queue, result valid and registers; no
// clearing pass, the glyph table and atlas are undefined until written.
// Stalls: the two-entry queue keeps accepting until full while the back end
// waits on res_ready; the result register holds until taken.
module font_atlas_glyph_renderer_core #(
    parameter int ATLAS_TEXELS = 65536,
    parameter int GLYPH_MAX_W  = 16,
    parameter int GLYPH_MAX_H  = 24,
    parameter int LANES        = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command channel
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  char_code,
    input  logic signed [15:0] pen_x,
    input  logic signed [15:0] pen_y,
    input  logic [9:0]  atlas_x,
    input  logic [9:0]  atlas_y,
    input  logic [4:0]  glyph_width,
    input  logic [4:0]  glyph_height,
    input  logic signed [7:0] glyph_offset_x,
    input  logic signed [7:0] glyph_offset_y,
    input  logic [7:0]  glyph_advance,
    input  logic [31:0] texel_word,
    // result channel
    output logic        res_valid,
    input  logic        res_ready,
    output logic        kind,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic [63:0] alphas,
    output logic [7:0]  lane_mask,
    output logic        last
);
    import fagr_pkg::*;

    cfg_t  cfg_reg;
    logic  wr_en;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    cmd_t  q_in;
    cmd_t  q_head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // decode on the word address; unused words read as zero
    always_comb
    begin
        case (paddr[3:2])
            REG_FONT_READY:  prdata = {31'd0, cfg_reg.font_ready};
            REG_ATLAS_WIDTH: prdata = {21'd0, cfg_reg.atlas_width};
            REG_LINE_PITCH:  prdata = {24'd0, cfg_reg.line_pitch};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.font_ready  <= 1'b0;
            cfg_reg.atlas_width <= ATLAS_WIDTH_RST;
            cfg_reg.line_pitch  <= LINE_PITCH_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_FONT_READY:  cfg_reg.font_ready  <= pwdata[0];
                REG_ATLAS_WIDTH: cfg_reg.atlas_width <= pwdata[10:0];
                REG_LINE_PITCH:  cfg_reg.line_pitch  <= pwdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classify and clamp incoming requests
    fagr_front #(.GLYPH_MAX_W(GLYPH_MAX_W), .GLYPH_MAX_H(GLYPH_MAX_H)) u_front (
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .command        (command),
        .char_code      (char_code),
        .pen_x          (pen_x),
        .pen_y          (pen_y),
        .atlas_x        (atlas_x),
        .atlas_y        (atlas_y),
        .glyph_width    (glyph_width),
        .glyph_height   (glyph_height),
        .glyph_offset_x (glyph_offset_x),
        .glyph_offset_y (glyph_offset_y),
        .glyph_advance  (glyph_advance),
        .texel_word     (texel_word),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    // decouple acceptance from execution
    fagr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // execute commands and drive the result register
    fagr_back #(.ATLAS_TEXELS(ATLAS_TEXELS), .LANES(LANES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .kind      (kind),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .alphas    (alphas),
        .lane_mask (lane_mask),
        .last      (last)
    );
endmodule

[hdl/fagr_checker.sv]
// Port-level checks of the renderer's result channel, bound to the top level.
// Depends only on the top level's ports.
module fagr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        kind,
    input logic [15:0] screen_x,
    input logic [15:0] screen_y,
    input logic [63:0] alphas,
    input logic [7:0]  lane_mask,
    input logic        last
);
    // hold a stalled result
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(screen_x) && $stable(screen_y)
            && $stable(alphas) && $stable(kind) && $stable(last))
        else $error("stalled result changed");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind |-> last && lane_mask == 8'd0 && alphas == 64'd0)
        else $error("done result malformed");

    a_chunk_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !kind |-> !last)
        else $error("chunk marked last");

    a_mask_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (lane_mask[0] == (alphas[7:0] != 8'd0))
            && (lane_mask[1] == (alphas[15:8] != 8'd0))
            && (lane_mask[2] == (alphas[23:16] != 8'd0))
            && (lane_mask[3] == (alphas[31:24] != 8'd0))
            && (lane_mask[4] == (alphas[39:32] != 8'd0))
            && (lane_mask[5] == (alphas[47:40] != 8'd0))
            && (lane_mask[6] == (alphas[55:48] != 8'd0))
            && (lane_mask[7] == (alphas[63:56] != 8'd0)))
        else $error("lane mask disagrees with alphas");
endmodule

bind font_atlas_glyph_renderer_core fagr_checker u_fagr_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for font_atlas_glyph_renderer_core: glyph, texel and pen commands in,
// pixel chunks and done results out, checked against an in-bench predictor.
// Depends on fagr_pkg and the RTL under hdl.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fagr_pkg::*;

    localparam int ATLAS_SIZE  = 65536;
    localparam int MAX_W       = 16;
    localparam int MAX_H       = 24;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  code;
        logic [15:0] px;
        logic [15:0] py;
        logic [9:0]  ax;
        logic [9:0]  ay;
        logic [4:0]  w;
        logic [4:0]  h;
        logic [7:0]  ox;
        logic [7:0]  oy;
        logic [7:0]  adv;
        logic [31:0] texel;
    } cmd_req_t;

    typedef struct {
        logic        kind;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [63:0] alphas;
        logic [7:0]  mask;
        logic        last;
    } blit_res_t;

    // Predicts the blitter and holds the results still owed by it.
    class glyph_blit_scoreboard;
        blit_res_t   owed_results[$];
        glyph_t      glyphs[GLYPH_COUNT];
        bit          loaded[GLYPH_COUNT];
        logic [7:0]  atlas[ATLAS_SIZE];
        bit          written[ATLAS_SIZE];
        logic [15:0] pen_x_q, pen_y_q, line_x_q;
        logic        ready_q;
        logic [10:0] width_q;
        logic [7:0]  lheight_q;
        int          errors;

        function new();
            pen_x_q = '0; pen_y_q = '0; line_x_q = '0;
            ready_q = 1'b0; width_q = ATLAS_WIDTH_RST; lheight_q = LINE_PITCH_RST;
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_FONT_READY:  ready_q = val[0];
                REG_ATLAS_WIDTH: width_q = val[10:0];
                REG_LINE_PITCH:  lheight_q = val[7:0];
                default: ;
            endcase
        endfunction

        function int texel_addr(int col, int row);
            return row * int'(width_q) + col;
        endfunction

        function void note_request(cmd_req_t r);
            blit_res_t   e;
            glyph_t      g;
            logic [15:0] bx, by;
            logic [63:0] al64;
            logic [7:0]  m, v;
            int          a, ix;
            case (r.cmd)
                CMD_GLYPH:
                begin
                    if (r.code >= FIRST_CODE && r.code <= LAST_CODE) begin
                        g.ax = r.ax; g.ay = r.ay;
                        g.w = (r.w > MAX_W) ? 5'(MAX_W) : r.w;
                        g.h = (r.h > MAX_H) ? 5'(MAX_H) : r.h;
                        g.offx = r.ox; g.offy = r.oy; g.adv = r.adv;
                        glyphs[r.code - FIRST_CODE] = g;
                        loaded[r.code - FIRST_CODE] = 1'b1;
                    end
                    return;
                end
                CMD_TEXEL:
                begin
                    a = texel_addr(r.ax, r.ay);
                    if (a < ATLAS_SIZE) begin
                        atlas[a] = r.texel[31:24];
                        written[a] = 1'b1;
                    end
                    return;
                end
                CMD_SET_PEN:
                begin
                    pen_x_q = r.px; pen_y_q = r.py; line_x_q = r.px;
                end
                default:
                begin
                    if (ready_q && r.code == NEWLINE_CODE) begin
                        pen_y_q = pen_y_q + 16'(lheight_q);
                        pen_x_q = line_x_q;
                    end else if (ready_q && r.code >= FIRST_CODE && r.code <= LAST_CODE) begin
                        g = glyphs[r.code - FIRST_CODE];
                        bx = pen_x_q + {{8{g.offx[7]}}, g.offx};
                        by = pen_y_q + {{8{g.offy[7]}}, g.offy};
                        for (int iy = 0; g.w != 0 && iy < g.h; iy++) begin
                            for (int cx = 0; cx < g.w; cx += 8) begin
                                al64 = '0; m = '0;
                                for (int lane = 0; lane < 8; lane++) begin
                                    ix = cx + lane;
                                    if (ix < g.w) begin
                                        a = texel_addr(int'(g.ax) + ix, int'(g.ay) + iy);
                                        v = (a < ATLAS_SIZE) ? atlas[a] : 8'd0;
                                        al64[8*lane +: 8] = v;
                                        if (v != 0) m[lane] = 1'b1;
                                    end
                                end
                                e.kind = 1'b0; e.sx = bx + 16'(cx); e.sy = by + 16'(iy);
                                e.alphas = al64; e.mask = m; e.last = 1'b0;
                                owed_results.push_back(e);
                            end
                        end
                        pen_x_q = pen_x_q + 16'(g.adv);
                    end
                end
            endcase
            e.kind = 1'b1; e.sx = pen_x_q; e.sy = pen_y_q;
            e.alphas = '0; e.mask = '0; e.last = 1'b1;
            owed_results.push_back(e);
        endfunction

        function void check_result(blit_res_t got);
            blit_res_t e;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d x=%h y=%h", $realtime,
                         got.kind, got.sx, got.sy);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (got.kind !== e.kind) begin
                $display("%0t: kind expected %0d actual %0d", $realtime, e.kind, got.kind);
                errors++;
            end
            if (got.sx !== e.sx) begin
                $display("%0t: screen_x expected %h actual %h", $realtime, e.sx, got.sx);
                errors++;
            end
            if (got.sy !== e.sy) begin
                $display("%0t: screen_y expected %h actual %h", $realtime, e.sy, got.sy);
                errors++;
            end
            if (got.alphas !== e.alphas) begin
                $display("%0t: alphas expected %h actual %h", $realtime, e.alphas, got.alphas);
                errors++;
            end
            if (got.mask !== e.mask) begin
                $display("%0t: lane_mask expected %h actual %h", $realtime, e.mask, got.mask);
                errors++;
            end
            if (got.last !== e.last) begin
                $display("%0t: last expected %0d actual %0d", $realtime, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        cmd_valid, cmd_ready;
    logic [1:0]  command;
    logic [7:0]  char_code;
    logic [15:0] pen_x, pen_y;
    logic [9:0]  atlas_x, atlas_y;
    logic [4:0]  glyph_width, glyph_height;
    logic [7:0]  glyph_offset_x, glyph_offset_y, glyph_advance;
    logic [31:0] texel_word;
    logic        res_valid, res_ready, kind, last;
    logic [15:0] screen_x, screen_y;
    logic [63:0] alphas;
    logic [7:0]  lane_mask;

    glyph_blit_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    int cycles;

    font_atlas_glyph_renderer_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .command(command),
        .char_code(char_code), .pen_x(pen_x), .pen_y(pen_y),
        .atlas_x(atlas_x), .atlas_y(atlas_y),
        .glyph_width(glyph_width), .glyph_height(glyph_height),
        .glyph_offset_x(glyph_offset_x), .glyph_offset_y(glyph_offset_y),
        .glyph_advance(glyph_advance), .texel_word(texel_word),
        .res_valid(res_valid), .res_ready(res_ready), .kind(kind),
        .screen_x(screen_x), .screen_y(screen_y), .alphas(alphas),
        .lane_mask(lane_mask), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: toggle ready at the falling edge, idling per the current phase.
    initial
    begin
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Take a result at each rising edge where it is handed over.
    always @(posedge clk)
    begin
        blit_res_t got;
        if (rst_n && res_valid && res_ready) begin
            got.kind = kind; got.sx = screen_x; got.sy = screen_y;
            got.alphas = alphas; got.mask = lane_mask; got.last = last;
            sb.check_result(got);
        end
    end

    // Present one request at the falling edge, hold it until accepted.
    task automatic send_request(cmd_req_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        command = r.cmd; char_code = r.code; pen_x = r.px; pen_y = r.py;
        atlas_x = r.ax; atlas_y = r.ay; glyph_width = r.w; glyph_height = r.h;
        glyph_offset_x = r.ox; glyph_offset_y = r.oy; glyph_advance = r.adv;
        texel_word = r.texel;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        sb.note_request(r);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result is back, plus load latency.
    task automatic drain();
        cmd_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    function automatic cmd_req_t blank_req(logic [1:0] cmd, logic [7:0] code);
        cmd_req_t r;
        r.cmd = cmd; r.code = code;
        r.px = 16'($urandom); r.py = 16'($urandom);
        r.ax = 10'($urandom); r.ay = 10'($urandom);
        r.w = 5'($urandom); r.h = 5'($urandom);
        r.ox = 8'($urandom); r.oy = 8'($urandom); r.adv = 8'($urandom);
        r.texel = $urandom;
        return r;
    endfunction

    // Find a column and row that land on atlas address a at the current width.
    function automatic bit texel_coords(int a, output logic [9:0] ax, output logic [9:0] ay);
        int w, row, col;
        w = int'(sb.width_q);
        if (w == 0) begin
            row = 0;
        end else begin
            row = (a > 1023) ? (a - 1023 + w - 1) / w : 0;
        end
        col = a - row * w;
        ax = 10'(col); ay = 10'(row);
        return (row <= 1023 && col >= 0 && col <= 1023);
    endfunction

    // Write every atlas texel the glyph will read that is still unwritten.
    task automatic fill_glyph(logic [7:0] code, output bit ok);
        glyph_t      g;
        cmd_req_t    r;
        logic [9:0]  ax, ay;
        int          a;
        g = sb.glyphs[code - FIRST_CODE];
        ok = 1'b1;
        for (int pass = 0; pass < 2 && ok; pass++) begin
            for (int iy = 0; g.w != 0 && iy < g.h; iy++) begin
                for (int ix = 0; ix < g.w; ix++) begin
                    a = sb.texel_addr(int'(g.ax) + ix, int'(g.ay) + iy);
                    if (a < ATLAS_SIZE && !sb.written[a]) begin
                        if (!texel_coords(a, ax, ay)) begin
                            ok = 1'b0;
                        end else if (pass == 1) begin
                            r = blank_req(CMD_TEXEL, 8'($urandom));
                            r.ax = ax; r.ay = ay;
                            // keep a fair share of transparent texels
                            if ($urandom_range(3) == 0) r.texel[31:24] = 8'd0;
                            send_request(r);
                        end
                    end
                end
            end
        end
    endtask

    task automatic load_glyph(logic [7:0] code, logic [9:0] ax, logic [9:0] ay,
                              logic [4:0] w, logic [4:0] h);
        cmd_req_t r;
        r = blank_req(CMD_GLYPH, code);
        r.ax = ax; r.ay = ay; r.w = w; r.h = h;
        send_request(r);
    endtask

    // Draw a loaded printable glyph; fall back to a nonprintable code if the
    // glyph was never loaded or its texels cannot be addressed at this width.
    task automatic draw_char(logic [7:0] code);
        bit ok;
        ok = 1'b1;
        if (code >= FIRST_CODE && code <= LAST_CODE && sb.ready_q) begin
            if (sb.loaded[code - FIRST_CODE]) fill_glyph(code, ok);
            else ok = 1'b0;
        end
        send_request(blank_req(CMD_DRAW, ok ? code : 8'd127));
    endtask

    task automatic set_pen(logic [15:0] x, logic [15:0] y);
        cmd_req_t r;
        r = blank_req(CMD_SET_PEN, 8'($urandom));
        r.px = x; r.py = y;
        send_request(r);
    endtask

    task automatic random_phase(int count);
        cmd_req_t r;
        int       roll, pick, tries;
        logic [4:0] w, h;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (n == count / 2) drain();   // hold off until all results are back
            if (roll < 15) begin
                set_pen(16'($urandom), 16'($urandom));
            end else if (roll < 35) begin
                w = ($urandom_range(9) == 0) ? 5'($urandom_range(9, 31))
                                              : 5'($urandom_range(0, 8));
                h = ($urandom_range(9) == 0) ? 5'($urandom_range(7, 31))
                                              : 5'($urandom_range(0, 6));
                r = blank_req(CMD_GLYPH, ($urandom_range(19) == 0) ? 8'($urandom)
                                         : 8'($urandom_range(32, 126)));
                r.w = w; r.h = h;
                if ($urandom_range(3) != 0) r.ay = 10'($urandom_range(0, 40));
                if ($urandom_range(3) != 0) r.ax = 10'($urandom_range(0, 1000));
                send_request(r);
            end else if (roll < 40) begin
                send_request(blank_req(CMD_TEXEL, 8'($urandom)));
            end else if (roll < 50) begin
                draw_char(($urandom_range(1) == 0) ? NEWLINE_CODE : 8'($urandom));
            end else begin
                pick = -1;
                tries = 0;
                while (pick < 0 && tries < 40) begin
                    tries++;
                    roll = $urandom_range(GLYPH_COUNT - 1);
                    if (sb.loaded[roll]) pick = roll;
                end
                if (pick < 0) begin
                    pick = $urandom_range(GLYPH_COUNT - 1);
                    load_glyph(8'(pick) + FIRST_CODE, 10'($urandom_range(0, 1000)),
                               10'($urandom_range(0, 40)), 5'($urandom_range(1, 8)),
                               5'($urandom_range(1, 4)));
                end
                draw_char(8'(pick) + FIRST_CODE);
            end
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        send_idle_pct = 33; recv_idle_pct = 50;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cmd_valid = 1'b0; command = CMD_SET_PEN; char_code = '0; pen_x = '0; pen_y = '0;
        atlas_x = '0; atlas_y = '0; glyph_width = '0; glyph_height = '0;
        glyph_offset_x = '0; glyph_offset_y = '0; glyph_advance = '0; texel_word = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: font not ready, every draw just reports the pen.
        apb_write(REG_FONT_READY, 32'd0);
        set_pen(16'h7FFF, 16'h8000);
        send_request(blank_req(CMD_DRAW, NEWLINE_CODE));
        send_request(blank_req(CMD_DRAW, 8'd200));
        drain();
        apb_write(REG_FONT_READY, 32'd1);

        // Loads for codes outside the printable range are dropped.
        load_glyph(8'd0, 10'd0, 10'd0, 5'd4, 5'd4);
        load_glyph(8'd255, 10'd0, 10'd0, 5'd4, 5'd4);
        load_glyph(LAST_CODE + 8'd1, 10'd0, 10'd0, 5'd4, 5'd4);
        // Oversize metrics clamp to the largest glyph; pen wraps on advance.
        load_glyph(8'd65, 10'd10, 10'd2, 5'd31, 5'd31);
        draw_char(8'd65);
        // Zero width: no chunks but the pen moves.
        load_glyph(FIRST_CODE, 10'd0, 10'd0, 5'd0, 5'd5);
        draw_char(FIRST_CODE);
        // Glyph past the end of the atlas reads as zero.
        load_glyph(LAST_CODE, 10'd1023, 10'd1023, 5'd3, 5'd2);
        draw_char(LAST_CODE);
        // Texel write at a random place; one beyond the atlas is ignored.
        send_request(blank_req(CMD_TEXEL, 8'd0));
        set_pen(16'd0, 16'd0);
        load_glyph(8'd66, 10'd500, 10'd7, 5'd9, 5'd1);
        draw_char(8'd66);
        draw_char(NEWLINE_CODE);
        draw_char(8'd0);
        draw_char(8'd31);
        draw_char(8'd127);
        draw_char(8'd255);
        set_pen(16'hFFFF, 16'h7FFF);
        draw_char(8'd66);
        drain();

        // Phase 1: sender idles a third, receiver half; narrow atlas, no line feed.
        apb_write(REG_ATLAS_WIDTH, 32'd64);
        apb_write(REG_LINE_PITCH, 32'd0);
        random_phase(35);
        drain();

        // Phase 2: roles swapped; atlas 1024 texels wide and tallest line.
        send_idle_pct = 50; recv_idle_pct = 33;
        apb_write(REG_ATLAS_WIDTH, 32'd1024);
        apb_write(REG_LINE_PITCH, 32'd255);
        random_phase(35);
        drain();

        // Phase 3: no idling; single-texel rows.
        send_idle_pct = 0; recv_idle_pct = 0;
        apb_write(REG_ATLAS_WIDTH, 32'd1);
        apb_write(REG_LINE_PITCH, 32'd37);
        random_phase(35);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
